// ----- design/mc6809_instruction_decoder_defines.svh -----
// assertion helpers for the 6809 decoder
`ifndef MC6809_INSTRUCTION_DECODER_DEFINES_SVH
`define MC6809_INSTRUCTION_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define M6809_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("m6809 check");
`define M6809_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("m6809 never");
`else
`define M6809_ASSERT_IMPL(label, clk, rst_n, prop)
`define M6809_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- design/m6809_pkg.sv -----
package m6809_pkg;

    localparam logic [7:0] MN_NONE  = 8'd255;
    localparam logic [7:0] MN_JMP   = 8'd12;
    localparam logic [7:0] MN_HALT  = 8'd16;
    localparam logic [7:0] MN_SWI2  = 8'd132;
    localparam logic [7:0] MN_SWI3  = 8'd139;
    localparam logic [7:0] MN_FLAG  = 8'd142;
    localparam logic [7:0] MN_BSR   = 8'd143;

    localparam logic [3:0] AM_INH  = 4'd0;
    localparam logic [3:0] AM_IMM8 = 4'd1;
    localparam logic [3:0] AM_IMM16 = 4'd2;
    localparam logic [3:0] AM_DIR  = 4'd3;
    localparam logic [3:0] AM_EXT  = 4'd4;
    localparam logic [3:0] AM_REL8 = 4'd5;
    localparam logic [3:0] AM_REL16 = 4'd6;
    localparam logic [3:0] AM_IDX  = 4'd7;
    localparam logic [3:0] AM_PAIR = 4'd8;
    localparam logic [3:0] AM_LIST = 4'd9;

    localparam logic [3:0] IK_NONE  = 4'd0;
    localparam logic [3:0] IK_OFF5  = 4'd1;
    localparam logic [3:0] IK_NOFF  = 4'd6;
    localparam logic [3:0] IK_BREG  = 4'd7;
    localparam logic [3:0] IK_AREG  = 4'd8;
    localparam logic [3:0] IK_DREG  = 4'd9;
    localparam logic [3:0] IK_OFF8  = 4'd10;
    localparam logic [3:0] IK_OFF16 = 4'd11;
    localparam logic [3:0] IK_PCR8  = 4'd12;
    localparam logic [3:0] IK_PCR16 = 4'd13;
    localparam logic [3:0] IK_EXTI  = 4'd14;

    // operand fetch kind after the opcode bytes
    typedef enum logic [3:0] {
        OK_NONE, OK_IMM8, OK_IMM16, OK_DIR, OK_EXT, OK_REL8, OK_REL16,
        OK_IDX, OK_PAIR, OK_LIST
    } opk_t;

    // result of stage 1 opcode decode
    typedef struct packed {
        logic [2:0] oplen;   // opcode bytes (1 or 2)
        logic       undef;
        logic [7:0] mn;
        opk_t       kind;
    } op_dec_t;

    function automatic logic [7:0] tab_ex1(input logic [3:0] l);
        logic [7:0] r;
        begin
            case (l)
                4'd0, 4'd1: r = 8'd0;
                4'd2: r = 8'd1;
                4'd3: r = 8'd2;
                4'd4, 4'd5: r = 8'd3;
                default: r = {4'd0, l} - 8'd2;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] tab_ex2(input logic [3:0] l);
        logic [7:0] r;
        begin
            case (l)
                4'd2: r = 8'd14;
                4'd3: r = 8'd15;
                4'd4, 4'd5: r = 8'd16;
                4'd6: r = 8'd17;
                4'd7: r = 8'd18;
                4'd8: r = 8'd19;
                4'd9: r = 8'd20;
                4'd10: r = 8'd21;
                4'd11: r = 8'd14;
                4'd12: r = 8'd22;
                4'd13: r = 8'd23;
                4'd14: r = 8'd24;
                4'd15: r = 8'd25;
                default: r = MN_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] tab_lea(input logic [3:0] l);
        logic [7:0] r;
        begin
            case (l)
                4'd8: r = 8'd22;
                4'd9: r = 8'd65;
                4'd10: r = 8'd66;
                4'd11: r = 8'd67;
                4'd12: r = 8'd68;
                4'd13: r = 8'd69;
                4'd14: r = 8'd70;
                4'd15: r = 8'd71;
                default: r = 8'd57 + {4'd0, l};
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] tab_inha(input logic [3:0] l);
        logic [7:0] r;
        begin
            case (l)
                4'd0, 4'd1: r = 8'd72;
                4'd2: r = 8'd73;
                4'd3: r = 8'd74;
                4'd4, 4'd5: r = 8'd75;
                default: r = 8'd70 + {4'd0, l};
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] tab_inhm(input logic [3:0] l);
        logic [7:0] r;
        begin
            case (l)
                4'd0: r = 8'd0;
                4'd3: r = 8'd2;
                4'd4: r = 8'd3;
                4'd6: r = 8'd4;
                4'd7: r = 8'd5;
                4'd8: r = 8'd6;
                4'd9: r = 8'd7;
                4'd10: r = 8'd8;
                4'd11: r = 8'd9;
                4'd12: r = 8'd10;
                4'd13: r = 8'd11;
                4'd15: r = 8'd13;
                default: r = MN_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic reg_ok(input logic [3:0] c);
        logic [15:0] m;
        begin
            m = 16'h0f3f;
            return m[c];
        end
    endfunction

    // operand class by column group
    function automatic opk_t by_group(input logic [1:0] g, input logic wide);
        opk_t r;
        begin
            case (g)
                2'd0: r = wide ? OK_IMM16 : OK_IMM8;
                2'd1: r = OK_DIR;
                2'd2: r = OK_IDX;
                default: r = OK_EXT;
            endcase
            return r;
        end
    endfunction

    // opcode and page decode
    function automatic op_dec_t dec_op(input logic [7:0] b0, input logic [7:0] b1);
        op_dec_t d;
        logic [3:0] hi, lo, h2, l2;
        logic wide;
        begin
            hi = b0[7:4];
            lo = b0[3:0];
            h2 = b1[7:4];
            l2 = b1[3:0];
            wide = (lo == 4'd3) || (lo == 4'd12) || (lo == 4'd14);
            d.oplen = 3'd1;
            d.undef = 1'b0;
            d.mn = MN_NONE;
            d.kind = OK_NONE;
            case (hi)
                4'd0:
                begin
                    d.mn = tab_ex1(lo);
                    d.kind = OK_DIR;
                end
                4'd1:
                begin
                    if (b0 == 8'h10)
                    begin
                        d.oplen = 3'd2;
                        if (b1 == 8'h3f)
                            d.mn = MN_SWI2;
                        else if (h2 == 4'd2)
                        begin
                            if (l2 == 4'd0)
                                d.undef = 1'b1;
                            else
                            begin
                                d.mn = 8'd41 + {4'd0, l2};
                                d.kind = OK_REL16;
                            end
                        end
                        else if (b1 >= 8'hc0)
                        begin
                            if (l2 <= 4'd13 || b1 == 8'hcf)
                                d.undef = 1'b1;
                            else
                            begin
                                d.mn = (l2 == 4'd14) ? 8'd133 : 8'd134;
                                d.kind = by_group(h2[1:0], 1'b1);
                            end
                        end
                        else if (b1 >= 8'h80)
                        begin
                            d.kind = by_group(h2[1:0], 1'b1);
                            if (l2 == 4'd3)
                                d.mn = 8'd135;
                            else if (l2 == 4'd12)
                                d.mn = 8'd136;
                            else if (l2 == 4'd14)
                                d.mn = 8'd137;
                            else if (l2 == 4'd15 && h2 != 4'd8)
                                d.mn = 8'd138;
                            else
                            begin
                                d.undef = 1'b1;
                                d.kind = OK_NONE;
                            end
                        end
                        else
                            d.undef = 1'b1;
                    end
                    else if (b0 == 8'h11)
                    begin
                        d.oplen = 3'd2;
                        if (b1 == 8'h3f)
                            d.mn = MN_SWI3;
                        else if (h2 >= 4'd8 && h2 <= 4'd11 && (l2 == 4'd3 || l2 == 4'd12))
                        begin
                            d.mn = (l2 == 4'd3) ? 8'd140 : 8'd141;
                            d.kind = by_group(h2[1:0], 1'b1);
                        end
                        else
                            d.undef = 1'b1;
                    end
                    else if (tab_ex2(lo) == MN_NONE)
                        d.undef = 1'b1;
                    else
                    begin
                        d.mn = tab_ex2(lo);
                        if (b0 == 8'h16 || b0 == 8'h17)
                            d.kind = OK_REL16;
                        else if (b0 == 8'h1a || b0 == 8'h1c)
                            d.kind = OK_IMM8;
                        else if (b0 == 8'h1e || b0 == 8'h1f)
                            d.kind = OK_PAIR;
                    end
                end
                4'd2:
                begin
                    d.mn = 8'd26 + {4'd0, lo};
                    d.kind = OK_REL8;
                end
                4'd3:
                begin
                    d.mn = tab_lea(lo);
                    if (b0 < 8'h34)
                        d.kind = OK_IDX;
                    else if (b0 < 8'h38)
                        d.kind = OK_LIST;
                    else if (b0 == 8'h38)
                        d.kind = OK_IMM8;
                end
                4'd4: d.mn = tab_inha(lo);
                4'd5: d.mn = tab_inha(lo) + 8'd14;
                4'd6, 4'd7:
                begin
                    if (lo != 4'd14 && tab_inhm(lo) == MN_NONE)
                        d.undef = 1'b1;
                    else
                    begin
                        d.mn = (lo == 4'd14) ? MN_JMP : tab_inhm(lo);
                        d.kind = hi[0] ? OK_EXT : OK_IDX;
                    end
                end
                4'd8, 4'd9, 4'd10, 4'd11:
                begin
                    if (b0 == 8'h87)
                    begin
                        d.mn = MN_FLAG;
                        d.kind = OK_IMM8;
                    end
                    else if (b0 == 8'h8f)
                    begin
                        d.mn = MN_FLAG;
                        d.kind = OK_IMM16;
                    end
                    else if (b0 == 8'h8d)
                    begin
                        d.mn = MN_BSR;
                        d.kind = OK_REL8;
                    end
                    else
                    begin
                        d.mn = 8'd100 + {4'd0, lo};
                        d.kind = by_group(hi[1:0], wide);
                    end
                end
                default:
                begin
                    if (b0 == 8'hc7)
                    begin
                        d.mn = MN_FLAG;
                        d.kind = OK_IMM8;
                    end
                    else if (b0 == 8'hcd)
                        d.mn = MN_HALT;
                    else if (b0 == 8'hcf)
                    begin
                        d.mn = MN_FLAG;
                        d.kind = OK_IMM16;
                    end
                    else
                    begin
                        d.mn = 8'd116 + {4'd0, lo};
                        d.kind = by_group(hi[1:0], wide);
                    end
                end
            endcase
            if (d.undef)
                d.mn = MN_NONE;
            return d;
        end
    endfunction

endpackage

// ----- design/mc6809_instruction_decoder.sv -----
// channel | signals                                   | direction
// in      | in_valid/in_ready, instr_addr, code_byte0-4 | request into decoder
// out     | out_valid/out_ready, byte_length .. target_addr | decoded request out
// three register stages: opcode decode, operand extract, target add
// one request per cycle sustained while out_ready does not stall; an accepted request
// passes the stage 1, stage 2 and stage 3 registers in order before out_valid rises
// rst_n clears the stage valid bits only; payload registers are not reset
// a stall on out_ready holds the last stage; an earlier stage holds only while the next is full
// a stage with no valid item still fills
`include "mc6809_instruction_decoder_defines.svh"
module mc6809_instruction_decoder
    import m6809_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] instr_addr,
    input  logic [7:0]  code_byte0,
    input  logic [7:0]  code_byte1,
    input  logic [7:0]  code_byte2,
    input  logic [7:0]  code_byte3,
    input  logic [7:0]  code_byte4,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_length,
    output logic        undefined_op,
    output logic [7:0]  mnemonic_code,
    output logic [3:0]  address_mode,
    output logic [3:0]  index_kind,
    output logic [1:0]  index_reg,
    output logic        indirect_flag,
    output logic [15:0] operand_value,
    output logic [15:0] target_addr
);

    // stage enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1 registers
    op_dec_t     d1_reg;
    logic [15:0] a1_reg;
    logic [7:0]  b1_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1_reg <= dec_op(code_byte0, code_byte1);
            a1_reg <= instr_addr;
            b1_reg[0] <= code_byte1;
            b1_reg[1] <= code_byte2;
            b1_reg[2] <= code_byte3;
            b1_reg[3] <= code_byte4;
        end
    end

    // stage 2: operand extraction after the opcode bytes
    logic [7:0]  p_s, q_s, r_s;
    logic [2:0]  len_next;
    logic        und_next;
    logic [7:0]  mn_next;
    logic [3:0]  mode_next, ik_next;
    logic [1:0]  ir_next;
    logic        ind_next, rel_next;
    logic [15:0] op_next;
    logic [3:0]  plo;

    always_comb
    begin
        p_s = d1_reg.oplen[1] ? b1_reg[1] : b1_reg[0];
        q_s = d1_reg.oplen[1] ? b1_reg[2] : b1_reg[1];
        r_s = d1_reg.oplen[1] ? b1_reg[3] : b1_reg[2];
        plo = p_s[3:0];
        len_next = d1_reg.oplen;
        und_next = d1_reg.undef;
        mn_next = d1_reg.mn;
        mode_next = AM_INH;
        ik_next = IK_NONE;
        ir_next = 2'd0;
        ind_next = 1'b0;
        rel_next = 1'b0;
        op_next = 16'd0;
        case (d1_reg.kind)
            OK_IMM8:
            begin
                mode_next = AM_IMM8;
                op_next = {8'd0, p_s};
                len_next = d1_reg.oplen + 3'd1;
            end
            OK_DIR:
            begin
                mode_next = AM_DIR;
                op_next = {8'd0, p_s};
                len_next = d1_reg.oplen + 3'd1;
            end
            OK_LIST:
            begin
                mode_next = AM_LIST;
                op_next = {8'd0, p_s};
                len_next = d1_reg.oplen + 3'd1;
            end
            OK_IMM16, OK_EXT, OK_REL16:
            begin
                mode_next = (d1_reg.kind == OK_IMM16) ? AM_IMM16 :
                            (d1_reg.kind == OK_EXT) ? AM_EXT : AM_REL16;
                rel_next = (d1_reg.kind == OK_REL16);
                op_next = {p_s, q_s};
                len_next = d1_reg.oplen + 3'd2;
            end
            OK_REL8:
            begin
                mode_next = AM_REL8;
                rel_next = 1'b1;
                op_next = {{8{p_s[7]}}, p_s};
                len_next = d1_reg.oplen + 3'd1;
            end
            OK_PAIR:
            begin
                mode_next = AM_PAIR;
                op_next = {8'd0, p_s};
                len_next = d1_reg.oplen + 3'd1;
                if (!reg_ok(p_s[7:4]) || !reg_ok(p_s[3:0]))
                begin
                    und_next = 1'b1;
                    mn_next = MN_NONE;
                end
            end
            OK_IDX:
            begin
                mode_next = AM_IDX;
                len_next = d1_reg.oplen + 3'd1;
                if (!p_s[7])
                begin
                    ik_next = IK_OFF5;
                    ir_next = p_s[6:5];
                    op_next = {{11{p_s[4]}}, p_s[4:0]};
                end
                else if (plo < 4'd4)
                begin
                    if (p_s[4] && !plo[0])
                        und_next = 1'b1;
                    else
                    begin
                        ik_next = 4'd2 + plo;
                        ir_next = p_s[6:5];
                        ind_next = p_s[4];
                    end
                end
                else if (plo == 4'd4 || plo == 4'd5 || plo == 4'd6 || plo == 4'd11)
                begin
                    ik_next = (plo == 4'd4) ? IK_NOFF : (plo == 4'd5) ? IK_BREG :
                              (plo == 4'd6) ? IK_AREG : IK_DREG;
                    ir_next = p_s[6:5];
                    ind_next = p_s[4];
                end
                else if (plo == 4'd8 || plo == 4'd12)
                begin
                    op_next = {{8{q_s[7]}}, q_s};
                    ind_next = p_s[4];
                    len_next = d1_reg.oplen + 3'd2;
                    if (plo[2])
                    begin
                        ik_next = IK_PCR8;
                        rel_next = 1'b1;
                    end
                    else
                    begin
                        ik_next = IK_OFF8;
                        ir_next = p_s[6:5];
                    end
                end
                else if (plo == 4'd9 || plo == 4'd13)
                begin
                    op_next = {q_s, r_s};
                    ind_next = p_s[4];
                    len_next = d1_reg.oplen + 3'd3;
                    if (plo[2])
                    begin
                        ik_next = IK_PCR16;
                        rel_next = 1'b1;
                    end
                    else
                    begin
                        ik_next = IK_OFF16;
                        ir_next = p_s[6:5];
                    end
                end
                else if (plo == 4'd15 && p_s[4])
                begin
                    ik_next = IK_EXTI;
                    ind_next = 1'b1;
                    op_next = {q_s, r_s};
                    len_next = d1_reg.oplen + 3'd3;
                end
                else
                    und_next = 1'b1;
                if (und_next)
                begin
                    ik_next = IK_NONE;
                    ir_next = 2'd0;
                    ind_next = 1'b0;
                    op_next = 16'd0;
                    rel_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    logic [2:0]  len2_reg;
    logic        und2_reg, ind2_reg, rel2_reg;
    logic [7:0]  mn2_reg;
    logic [3:0]  mode2_reg, ik2_reg;
    logic [1:0]  ir2_reg;
    logic [15:0] op2_reg, a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            len2_reg <= len_next;
            und2_reg <= und_next;
            mn2_reg <= mn_next;
            mode2_reg <= mode_next;
            ik2_reg <= ik_next;
            ir2_reg <= ir_next;
            ind2_reg <= ind_next;
            rel2_reg <= rel_next;
            op2_reg <= op_next;
            a2_reg <= a1_reg;
        end
    end

    // stage 3: relative target add
    logic [15:0] targ_next;
    assign targ_next = rel2_reg ? (a2_reg + {13'd0, len2_reg} + op2_reg) : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            byte_length <= len2_reg;
            undefined_op <= und2_reg;
            mnemonic_code <= mn2_reg;
            address_mode <= mode2_reg;
            index_kind <= ik2_reg;
            index_reg <= ir2_reg;
            indirect_flag <= ind2_reg;
            operand_value <= op2_reg;
            target_addr <= targ_next;
        end
    end

    assign out_valid = v3_reg;

    // checks
    `M6809_ASSERT_IMPL(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)
    `M6809_ASSERT_NEVER(a_len_range, clk, rst_n, out_valid && (byte_length == 3'd0 || byte_length > 3'd5))
    `M6809_ASSERT_NEVER(a_undef_mn, clk, rst_n, out_valid && undefined_op && address_mode != AM_IDX && mnemonic_code != MN_NONE)

endmodule
